// ----- design/plled_pkg.sv -----
// Shared types and constants for the press length LED controller.
`timescale 1ns / 1ps

package plled_pkg;

   // Width of the wrapping millisecond time base
   localparam int TIME_BITS = 32;
   localparam int CFG_BITS = 16;
   localparam int COUNT_BITS = 16;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_SHORT_LIMIT = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MEDIUM_LIMIT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FLASH = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PERIOD_ONE = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PERIOD_TWO = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PERIOD_OTHER = 3'd5;

   // Configuration reset values
   localparam logic [CFG_BITS-1:0] SHORT_LIMIT_RESET = 16'd1500;
   localparam logic [CFG_BITS-1:0] MEDIUM_LIMIT_RESET = 16'd4000;
   localparam logic [CFG_BITS-1:0] FLASH_RESET = 16'd500;
   localparam logic [CFG_BITS-1:0] PERIOD_ONE_RESET = 16'd1000;
   localparam logic [CFG_BITS-1:0] PERIOD_TWO_RESET = 16'd2000;
   localparam logic [CFG_BITS-1:0] PERIOD_OTHER_RESET = 16'd3000;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_SHORT = 2'd1,
      KIND_MEDIUM = 2'd2,
      KIND_LONG = 2'd3
   } press_kind_type;

endpackage

// ----- design/press_length_led_controller_unit.sv -----
// Top level of the press length LED controller: tick pipeline and LED state.
`timescale 1ns / 1ps
// Path: a transaction accepted into the input register is presented on the result port
//   from the result register, when not stalled.
// Throughput: one tick transaction per cycle while the result side does not stall; the
//   state update is a single pass of compares and two 32-bit subtracts between the two registers.
// Reset (synchronous, active high): empties both stages, clears all state and
//   loads the configuration registers with their defaults.
module press_length_led_controller_unit (
   input  logic                             clock,
   input  logic                             reset,
   // tick channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_button_down,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_led,
   output logic [1:0]                       rsp_press_kind,
   output logic [plled_pkg::COUNT_BITS-1:0] rsp_short_count,
   // configuration write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [plled_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [plled_pkg::CFG_BITS-1:0]       csr_data
);

   // Configuration registers
   logic [plled_pkg::CFG_BITS-1:0] short_limit_ff, medium_limit_ff, flash_ff;
   logic [plled_pkg::CFG_BITS-1:0] period_one_ff, period_two_ff, period_other_ff;

   // Input stage
   logic s1_valid_ff, s1_down_ff;

   // Result stage
   logic                             out_valid_ff;
   logic                             led_ff;
   plled_pkg::press_kind_type        kind_ff;
   logic [plled_pkg::COUNT_BITS-1:0] count_ff;

   // Controller state
   logic [plled_pkg::TIME_BITS-1:0]  now_ff, hold_start_ff, flash_start_ff;
   logic                             held_ff, blinking_ff, lit_ff;
   logic [plled_pkg::COUNT_BITS-1:0] presses_ff;
   logic [plled_pkg::CFG_BITS-1:0]   blink_period_ff;

   // Next-state values
   logic [plled_pkg::TIME_BITS-1:0]  now_in, hold_start_in, flash_start_in;
   logic                             held_in, blinking_in, lit_in;
   logic [plled_pkg::COUNT_BITS-1:0] presses_in;
   logic [plled_pkg::CFG_BITS-1:0]   blink_period_in;
   plled_pkg::press_kind_type        kind_in;

   // Pipeline control
   logic out_take;   // result stage can load this cycle
   logic advance;    // the held tick is processed and moves to the result stage

   assign out_take  = !out_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_take;
   // Stall only while a tick sits in the input stage and cannot move on
   assign req_stall = s1_valid_ff && !out_take;
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------------
   // Configuration writes; unknown indexes are dropped.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         short_limit_ff  <= plled_pkg::SHORT_LIMIT_RESET;
         medium_limit_ff <= plled_pkg::MEDIUM_LIMIT_RESET;
         flash_ff        <= plled_pkg::FLASH_RESET;
         period_one_ff   <= plled_pkg::PERIOD_ONE_RESET;
         period_two_ff   <= plled_pkg::PERIOD_TWO_RESET;
         period_other_ff <= plled_pkg::PERIOD_OTHER_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            plled_pkg::REG_SHORT_LIMIT:  short_limit_ff  <= csr_data;
            plled_pkg::REG_MEDIUM_LIMIT: medium_limit_ff <= csr_data;
            plled_pkg::REG_FLASH:        flash_ff        <= csr_data;
            plled_pkg::REG_PERIOD_ONE:   period_one_ff   <= csr_data;
            plled_pkg::REG_PERIOD_TWO:   period_two_ff   <= csr_data;
            plled_pkg::REG_PERIOD_OTHER: period_other_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Input stage: capture a tick whenever the stage is empty or draining.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         s1_down_ff <= req_button_down;
      end
   end

   // ---------------------------------------------------------------------
   // Tick processing: press tracking, classification on release, then the
   // flash end check and the blink restart, all against the current time.
   // ---------------------------------------------------------------------
   always_comb begin
      logic [plled_pkg::TIME_BITS-1:0] dur;
      logic [plled_pkg::TIME_BITS-1:0] flash_age;
      logic                            flash_over;
      logic                            blink_due;

      held_in         = held_ff;
      hold_start_in   = hold_start_ff;
      presses_in      = presses_ff;
      blinking_in     = blinking_ff;
      blink_period_in = blink_period_ff;
      lit_in          = lit_ff;
      flash_start_in  = flash_start_ff;
      kind_in         = plled_pkg::KIND_NONE;
      now_in          = now_ff + 1'b1;

      // Press starts: note the time
      if (s1_down_ff && !held_ff) begin
         held_in       = 1'b1;
         hold_start_in = now_ff;
      end

      // Release: classify by the wrapped duration
      dur = now_ff - hold_start_ff;
      if (!s1_down_ff && held_ff) begin
         held_in = 1'b0;
         if (dur <= plled_pkg::TIME_BITS'(short_limit_ff)) begin
            kind_in = plled_pkg::KIND_SHORT;
            if (presses_ff != plled_pkg::COUNT_MAX) begin
               presses_in = presses_ff + 1'b1;
            end
            lit_in         = 1'b1;
            flash_start_in = now_ff;
         end else if (dur <= plled_pkg::TIME_BITS'(medium_limit_ff)) begin
            kind_in = plled_pkg::KIND_MEDIUM;
            if (presses_ff == plled_pkg::COUNT_BITS'(1)) begin
               blink_period_in = period_one_ff;
            end else if (presses_ff == plled_pkg::COUNT_BITS'(2)) begin
               blink_period_in = period_two_ff;
            end else begin
               blink_period_in = period_other_ff;
            end
            blinking_in    = 1'b1;
            lit_in         = 1'b1;
            flash_start_in = now_ff;
         end else begin
            kind_in     = plled_pkg::KIND_LONG;
            blinking_in = 1'b0;
            presses_in  = '0;
            lit_in      = 1'b0;
         end
      end

      // Flash end, then blink restart; both use the same flash age
      flash_age  = now_ff - flash_start_in;
      flash_over = flash_age >= plled_pkg::TIME_BITS'(flash_ff);
      blink_due  = flash_age >= plled_pkg::TIME_BITS'(blink_period_in);
      if (lit_in && flash_over) begin
         lit_in = 1'b0;
      end
      if (blinking_in && !lit_in && blink_due) begin
         lit_in         = 1'b1;
         flash_start_in = now_ff;
      end
   end

   // Commit state only when the tick advances into the result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff          <= '0;
         hold_start_ff   <= '0;
         flash_start_ff  <= '0;
         held_ff         <= 1'b0;
         blinking_ff     <= 1'b0;
         lit_ff          <= 1'b0;
         presses_ff      <= '0;
         blink_period_ff <= '0;
      end else if (advance) begin
         now_ff          <= now_in;
         hold_start_ff   <= hold_start_in;
         flash_start_ff  <= flash_start_in;
         held_ff         <= held_in;
         blinking_ff     <= blinking_in;
         lit_ff          <= lit_in;
         presses_ff      <= presses_in;
         blink_period_ff <= blink_period_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result stage: hold while stalled, load when a tick advances.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_take) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         led_ff   <= lit_in;
         kind_ff  <= kind_in;
         count_ff <= presses_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_led         = led_ff;
   assign rsp_press_kind  = kind_ff;
   assign rsp_short_count = count_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // Time advances by exactly one per processed tick
   a_time_step: assert property (@(posedge clock) disable iff (reset)
      advance |=> now_ff == $past(now_ff) + 1'b1)
      else $error("time base did not advance by one");

   // A classified release always ends the press
   a_release_ends_press: assert property (@(posedge clock) disable iff (reset)
      (advance && kind_in != plled_pkg::KIND_NONE) |=> !held_ff)
      else $error("press still held after release");

   // A long press leaves the LED dark and the count cleared in its result
   a_long_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && kind_in == plled_pkg::KIND_LONG) |=>
         (!rsp_led && rsp_short_count == '0 && !blinking_ff))
      else $error("long press did not clear LED and count");

   // The input stage never stalls while the result stage is free
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      (!out_valid_ff || !rsp_stall) |-> !req_stall)
      else $error("stall raised with room in the result stage");

endmodule

// ----- bench/tb_press_length_led_controller_unit.sv -----
// Self-checking testbench for press_length_led_controller_unit: tick stimulus and LED prediction.
`timescale 1ns / 1ps

module tb_press_length_led_controller_unit;

   // Indexes that decode to no register; writes to them must change nothing
   localparam logic [plled_pkg::CSR_INDEX_BITS-1:0] REG_SPARE_SIX = 3'd6;
   localparam logic [plled_pkg::CSR_INDEX_BITS-1:0] REG_SPARE_SEVEN = 3'd7;
   // Two register stages inside the block; give it a little more before a write
   localparam int DRAIN_CYCLES = 4;
   // Longest press used in random traffic, keeps the sets short
   localparam int unsigned HOLD_CAP = 60;

   typedef struct packed {
      logic                             led;
      plled_pkg::press_kind_type        kind;
      logic [plled_pkg::COUNT_BITS-1:0] count;
   } tick_expect_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic                                 req_button_down = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic                                 rsp_led;
   logic [1:0]                           rsp_press_kind;
   logic [plled_pkg::COUNT_BITS-1:0]     rsp_short_count;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [plled_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [plled_pkg::CFG_BITS-1:0]       csr_data = '0;

   // Predicted LED controller: configuration copy
   logic [plled_pkg::CFG_BITS-1:0] lim_short = plled_pkg::SHORT_LIMIT_RESET;
   logic [plled_pkg::CFG_BITS-1:0] lim_medium = plled_pkg::MEDIUM_LIMIT_RESET;
   logic [plled_pkg::CFG_BITS-1:0] flash_len = plled_pkg::FLASH_RESET;
   logic [plled_pkg::CFG_BITS-1:0] gap_one = plled_pkg::PERIOD_ONE_RESET;
   logic [plled_pkg::CFG_BITS-1:0] gap_two = plled_pkg::PERIOD_TWO_RESET;
   logic [plled_pkg::CFG_BITS-1:0] gap_other = plled_pkg::PERIOD_OTHER_RESET;

   // Predicted LED controller: running state
   logic [plled_pkg::TIME_BITS-1:0]  clock_ms = '0;
   logic [plled_pkg::TIME_BITS-1:0]  press_start = '0;
   logic [plled_pkg::TIME_BITS-1:0]  flash_from = '0;
   logic                             pressed = 1'b0;
   logic                             blink_on = 1'b0;
   logic                             led_on = 1'b0;
   logic [plled_pkg::COUNT_BITS-1:0] short_presses = '0;
   logic [plled_pkg::CFG_BITS-1:0]   blink_gap = '0;

   tick_expect_type expected_ticks[$];
   int              failures = 0;
   int unsigned     ticks_sent = 0;
   int unsigned     burst_left = 0;
   logic            quiet_sender = 1'b0;
   stall_mode_type  stall_mode = STALL_NONE;
   int unsigned     stall_left = 0;

   press_length_led_controller_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_button_down (req_button_down),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_led         (rsp_led),
      .rsp_press_kind  (rsp_press_kind),
      .rsp_short_count (rsp_short_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   // Advance the predicted controller by one millisecond tick.
   // Differences of time values wrap at TIME_BITS, as in the block.
   task automatic predict_tick(input logic down, output tick_expect_type res);
      plled_pkg::press_kind_type       kind;
      logic [plled_pkg::TIME_BITS-1:0] held_for;
      kind = plled_pkg::KIND_NONE;
      if (down && !pressed) begin
         pressed = 1'b1;
         press_start = clock_ms;
      end
      if (!down && pressed) begin
         held_for = clock_ms - press_start;
         pressed = 1'b0;
         // short is tested first, so out-of-order limits shrink the medium class
         if (held_for <= plled_pkg::TIME_BITS'(lim_short)) begin
            kind = plled_pkg::KIND_SHORT;
            if (short_presses != plled_pkg::COUNT_MAX)
               short_presses = short_presses + 1'b1;
            led_on = 1'b1;
            flash_from = clock_ms;
         end else if (held_for <= plled_pkg::TIME_BITS'(lim_medium)) begin
            kind = plled_pkg::KIND_MEDIUM;
            if (short_presses == plled_pkg::COUNT_BITS'(1))
               blink_gap = gap_one;
            else if (short_presses == plled_pkg::COUNT_BITS'(2))
               blink_gap = gap_two;
            else
               blink_gap = gap_other;
            blink_on = 1'b1;
            led_on = 1'b1;
            flash_from = clock_ms;
         end else begin
            kind = plled_pkg::KIND_LONG;
            blink_on = 1'b0;
            short_presses = '0;
            led_on = 1'b0;
         end
      end
      // a zero flash time darkens the LED on the very tick it lit
      if (led_on && (clock_ms - flash_from) >= plled_pkg::TIME_BITS'(flash_len))
         led_on = 1'b0;
      if (blink_on && !led_on &&
          (clock_ms - flash_from) >= plled_pkg::TIME_BITS'(blink_gap)) begin
         led_on = 1'b1;
         flash_from = clock_ms;
      end
      res.led = led_on;
      res.kind = kind;
      res.count = short_presses;
      clock_ms = clock_ms + 1'b1;
   endtask

   // Send one tick transaction. The sender runs in bursts; between bursts it
   // drops valid for a random gap, unless the quiet flag holds it off.
   task automatic send_tick(input logic down);
      tick_expect_type res;
      int unsigned     gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
         if ($urandom_range(0, 19) == 0)
            gap = $urandom_range(9, 24);
         if (quiet_sender)
            gap = 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_button_down <= down;
      // hold the payload until the block takes it
      do @(posedge clock); while (req_stall);
      predict_tick(down, res);
      expected_ticks.push_back(res);
      ticks_sent++;
   endtask

   // One press: hold ticks with the button down, then rest ticks released.
   task automatic press(input int unsigned hold, input int unsigned rest);
      repeat (hold) send_tick(1'b1);
      repeat (rest) send_tick(1'b0);
   endtask

   // Drop valid and wait until every predicted result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_ticks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write transaction; mirror it in the predicted configuration.
   task automatic put_reg(input logic [plled_pkg::CSR_INDEX_BITS-1:0] idx,
                          input logic [plled_pkg::CFG_BITS-1:0] word);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= word;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         plled_pkg::REG_SHORT_LIMIT:  lim_short = word;
         plled_pkg::REG_MEDIUM_LIMIT: lim_medium = word;
         plled_pkg::REG_FLASH:        flash_len = word;
         plled_pkg::REG_PERIOD_ONE:   gap_one = word;
         plled_pkg::REG_PERIOD_TWO:   gap_two = word;
         plled_pkg::REG_PERIOD_OTHER: gap_other = word;
         default: ;
      endcase
   endtask

   // Let the block go idle, then write every register, spare indexes included.
   task automatic load_settings(
         input logic [plled_pkg::CFG_BITS-1:0] short_ms, medium_ms, flash_set,
         input logic [plled_pkg::CFG_BITS-1:0] period_one, period_two, period_other);
      drain();
      put_reg(plled_pkg::REG_SHORT_LIMIT, short_ms);
      put_reg(REG_SPARE_SIX, plled_pkg::CFG_BITS'($urandom));
      put_reg(plled_pkg::REG_MEDIUM_LIMIT, medium_ms);
      put_reg(plled_pkg::REG_FLASH, flash_set);
      put_reg(plled_pkg::REG_PERIOD_ONE, period_one);
      put_reg(REG_SPARE_SEVEN, plled_pkg::CFG_BITS'($urandom));
      put_reg(plled_pkg::REG_PERIOD_TWO, period_two);
      put_reg(plled_pkg::REG_PERIOD_OTHER, period_other);
      csr_valid <= 1'b0;
   endtask

   // Random register value in a range.
   function automatic logic [plled_pkg::CFG_BITS-1:0] pick_cfg(input int unsigned lo,
                                                               input int unsigned hi);
      return plled_pkg::CFG_BITS'($urandom_range(lo, hi));
   endfunction

   // Press length for random traffic, biased onto the class boundaries.
   function automatic int unsigned pick_hold();
      int unsigned hold;
      case ($urandom_range(0, 5))
         0: hold = 32'(lim_short);
         1: hold = 32'(lim_short) + 1;
         2: hold = 32'(lim_medium);
         3: hold = 32'(lim_medium) + 1;
         default: hold = $urandom_range(1, HOLD_CAP);
      endcase
      if (hold == 0 || hold > HOLD_CAP)
         hold = $urandom_range(1, HOLD_CAP);
      return hold;
   endfunction

   // Mostly well-formed presses with random lengths; the rest is button noise.
   task automatic random_traffic(input int unsigned amount);
      int unsigned start;
      int unsigned noise;
      start = ticks_sent;
      while (ticks_sent - start < amount) begin
         if ($urandom_range(0, 4) == 0) begin
            noise = $urandom_range(1, 10);
            repeat (noise) send_tick($urandom_range(0, 1) != 0);
         end else begin
            press(pick_hold(), $urandom_range(1, 24));
         end
      end
   endtask

   // Reset settings: idle ticks, then one short press and part of its flash.
   task automatic test_power_on();
      repeat (4) send_tick(1'b0);
      press(2, 4);
   endtask

   // Reset settings: more short presses, count stepping and the start of each flash.
   task automatic test_reset_values();
      press(3, 8);
      press(1, 6);
   endtask

   task automatic test_special_cases();
      // zero blink period: relight on the same tick that each flash ends
      load_settings(16'd2, 16'd4, 16'd2, 16'd0, 16'd0, 16'd0);
      press(1, 2);
      press(3, 6);
      // limits out of order and a zero flash time
      load_settings(16'd5, 16'd2, 16'd0, 16'd0, 16'd0, 16'd0);
      press(4, 2);
      press(6, 2);
      press(1, 2);
   endtask

   task automatic test_random_settings();
      logic [plled_pkg::CFG_BITS-1:0] s;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               s = pick_cfg(1, 15);
               load_settings(s, pick_cfg(32'(s) + 1, 32'(s) + 20), pick_cfg(1, 10),
                             pick_cfg(1, 12), pick_cfg(1, 12), pick_cfg(1, 12));
            end
            1: load_settings('0, '0, '0, '0, '0, '0);
            2: load_settings('1, '1, '1, '1, '1, '1);
            3: begin
               s = pick_cfg(8, 30);
               load_settings(s, pick_cfg(0, 32'(s) - 1), pick_cfg(0, 6),
                             pick_cfg(0, 8), pick_cfg(0, 8), pick_cfg(0, 8));
            end
            4: load_settings('0, pick_cfg(1, 30), pick_cfg(1, 8),
                             pick_cfg(0, 20), pick_cfg(0, 20), pick_cfg(0, 20));
            5: begin
               s = pick_cfg(1, 10);
               load_settings(s, pick_cfg(32'(s), 32'(s) + 25), '0,
                             pick_cfg(0, 15), pick_cfg(0, 15), pick_cfg(0, 15));
            end
            6: load_settings(pick_cfg(1, 6), pick_cfg(7, 20), pick_cfg(0, 10),
                             '1, '1, '1);
            default: load_settings(plled_pkg::CFG_BITS'($urandom),
                                   plled_pkg::CFG_BITS'($urandom),
                                   plled_pkg::CFG_BITS'($urandom),
                                   plled_pkg::CFG_BITS'($urandom),
                                   plled_pkg::CFG_BITS'($urandom),
                                   plled_pkg::CFG_BITS'($urandom));
         endcase
         random_traffic(100);
      end
   endtask

   // Step the short count with back-to-back one-tick presses, then a medium
   // press at a count above two and a long press that clears it.
   task automatic test_count_run();
      load_settings(16'd1, 16'd3, 16'd1, 16'd2, 16'd3, 16'd4);
      quiet_sender = 1'b1;
      repeat (12) press(1, 1);
      press(2, 6);  // medium picks the catch-all period
      press(4, 3);  // long clears the count again
      quiet_sender = 1'b0;
   endtask

   // Receiver: stall on a pattern that changes mode every so often.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(16, 200);
      end
      stall_left--;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= ((stall_left % 16) < 11);
      endcase
   end

   // Compare each result transaction against the oldest prediction.
   always @(posedge clock) begin
      tick_expect_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_ticks.size() == 0) begin
            $error("unexpected result: led %0d kind %0d count %0d",
                   rsp_led, rsp_press_kind, rsp_short_count);
            failures++;
         end else begin
            want = expected_ticks.pop_front();
            if (rsp_led !== want.led) begin
               $error("led: expected %0d, actual %0d", want.led, rsp_led);
               failures++;
            end
            if (rsp_press_kind !== want.kind) begin
               $error("press_kind: expected %0d, actual %0d", want.kind, rsp_press_kind);
               failures++;
            end
            if (rsp_short_count !== want.count) begin
               $error("short_count: expected %0d, actual %0d", want.count, rsp_short_count);
               failures++;
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_power_on();
      test_reset_values();
      test_special_cases();
      test_random_settings();
      test_count_run();
      drain();
      if (failures == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Watchdog: several times the slowest legal run
   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- sim.f -----
design/plled_pkg.sv
design/press_length_led_controller_unit.sv
bench/tb_press_length_led_controller_unit.sv
